// ----- sv/mp3_frame_header_parser_assert.svh -----
// Assertion macros shared by the frame header parser RTL.
// Expects signals clk and rst_n in the including module's scope.
`ifndef MP3_FRAME_HEADER_PARSER_ASSERT_SVH
`define MP3_FRAME_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MFHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define MFHP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mfhp_pkg.sv -----
// Types, constants and lookup tables for the frame header parser.
// No dependencies; used by the decode stage, divider cells and top level.
package mfhp_pkg;

  localparam int QBITS   = 11;              // quotient bits, one per divider cell
  localparam int RATE_W  = 16;
  localparam int KBPS_W  = 9;
  localparam int DIV_W   = RATE_W + 1;      // sample rate shifted by lsf
  localparam int DVD_W   = 26;              // kbps * 144000 fits below 2^26
  localparam int DSH_W   = DIV_W + QBITS - 1;
  localparam int SIZE_W  = 11;
  localparam int CH_W    = 2;
  localparam int FSC_W   = 18;

  localparam logic [FSC_W-1:0] FRAME_SCALE = 18'd144000;

  localparam logic [CH_W-1:0] CH_MONO   = 2'd1;
  localparam logic [CH_W-1:0] CH_STEREO = 2'd2;
  localparam logic [1:0]      MODE_MONO = 2'b11;
  localparam logic [1:0]      LAYER_III = 2'b01;
  localparam logic [1:0]      FIDX_RSVD = 2'b11;

  typedef struct packed {
    logic              ok;
    logic              pad;
    logic [CH_W-1:0]   chans;
    logic [RATE_W-1:0] rate;
    logic [KBPS_W-1:0] kbps;
    logic [DVD_W-1:0]  rem;
    logic [DSH_W-1:0]  dsh;
    logic [QBITS-1:0]  quo;
  } div_data_t;

  function automatic logic [RATE_W-1:0] rate_lut(input logic [3:0] idx);
    logic [RATE_W-1:0] r;
    unique case (idx)
      4'd0:    r = 16'd44100;
      4'd1:    r = 16'd48000;
      4'd2:    r = 16'd32000;
      4'd3:    r = 16'd22050;
      4'd4:    r = 16'd24000;
      4'd5:    r = 16'd16000;
      4'd6:    r = 16'd11025;
      4'd7:    r = 16'd12000;
      4'd8:    r = 16'd8000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [KBPS_W-1:0] kbps_lut(input logic lsf, input logic [3:0] idx);
    logic [KBPS_W-1:0] k;
    if (!lsf) begin
      unique case (idx)
        4'd1:    k = 9'd32;
        4'd2:    k = 9'd40;
        4'd3:    k = 9'd48;
        4'd4:    k = 9'd56;
        4'd5:    k = 9'd64;
        4'd6:    k = 9'd80;
        4'd7:    k = 9'd96;
        4'd8:    k = 9'd112;
        4'd9:    k = 9'd128;
        4'd10:   k = 9'd160;
        4'd11:   k = 9'd192;
        4'd12:   k = 9'd224;
        4'd13:   k = 9'd256;
        4'd14:   k = 9'd320;
        default: k = 9'd0;
      endcase
    end else begin
      unique case (idx)
        4'd1:    k = 9'd8;
        4'd2:    k = 9'd16;
        4'd3:    k = 9'd24;
        4'd4:    k = 9'd32;
        4'd5:    k = 9'd40;
        4'd6:    k = 9'd48;
        4'd7:    k = 9'd56;
        4'd8:    k = 9'd64;
        4'd9:    k = 9'd80;
        4'd10:   k = 9'd96;
        4'd11:   k = 9'd112;
        4'd12:   k = 9'd128;
        4'd13:   k = 9'd144;
        4'd14:   k = 9'd160;
        default: k = 9'd0;
      endcase
    end
    return k;
  endfunction

endpackage

// ----- sv/mfhp_decode.sv -----
// Front stage: header checks, table lookups and the bitrate scaling multiply.
// Depends on mfhp_pkg; feeds the first divider cell.
module mfhp_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_vld,
  output logic                up_rdy,
  input  logic [31:0]         hdr,
  output logic                dn_vld,
  input  logic                dn_rdy,
  output mfhp_pkg::div_data_t dn_data
);
  import mfhp_pkg::*;

  logic              vld_r;
  div_data_t         data_r;
  div_data_t         data_nxt;
  logic              ok;
  logic              lsf;
  logic [3:0]        row;
  logic [3:0]        bidx;
  logic [1:0]        fidx;
  logic [RATE_W-1:0] rate;
  logic [KBPS_W-1:0] kbps;
  logic [DIV_W-1:0]  div;
  logic [DVD_W-1:0]  prod;

  assign fidx = hdr[11:10];
  assign bidx = hdr[15:12];

  always_comb begin
    ok = (&hdr[31:21]) && !(&hdr[15:10]) && (hdr[18:17] == LAYER_III) &&
         (fidx != FIDX_RSVD) && (bidx != 4'd0) && (bidx != 4'd15);
    if (hdr[20]) begin
      lsf = !hdr[19];
      row = hdr[19] ? 4'd0 : 4'd3;
    end else begin
      lsf = 1'b1;
      row = 4'd6;
    end
    rate = ok ? rate_lut(row + {2'b00, fidx}) : '0;
    kbps = ok ? kbps_lut(lsf, bidx) : '0;
    div  = lsf ? {rate, 1'b0} : {1'b0, rate};
    prod = DVD_W'(kbps) * DVD_W'(FRAME_SCALE);

    data_nxt       = '0;
    data_nxt.ok    = ok;
    data_nxt.pad   = hdr[9];
    data_nxt.chans = !ok ? '0 : ((hdr[7:6] == MODE_MONO) ? CH_MONO : CH_STEREO);
    data_nxt.rate  = rate;
    data_nxt.kbps  = kbps;
    data_nxt.rem   = prod;
    data_nxt.dsh   = {div, {(QBITS-1){1'b0}}};
    data_nxt.quo   = '0;
  end

  assign up_rdy = !vld_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      data_r <= data_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_data = data_r;
endmodule

// ----- sv/mfhp_div_cell.sv -----
// One restoring-division cell: resolves one quotient bit, halves the divisor.
// Depends on mfhp_pkg; cells are chained in the top level.
module mfhp_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_vld,
  output logic                up_rdy,
  input  mfhp_pkg::div_data_t up_data,
  output logic                dn_vld,
  input  logic                dn_rdy,
  output mfhp_pkg::div_data_t dn_data
);
  import mfhp_pkg::*;

  logic            vld_r;
  div_data_t       data_r;
  div_data_t       data_nxt;
  logic [DSH_W:0]  diff;
  logic            take;

  always_comb begin
    diff     = {1'b0, DSH_W'(up_data.rem)} - {1'b0, up_data.dsh};
    take     = !diff[DSH_W];
    data_nxt = up_data;
    data_nxt.rem = take ? diff[DVD_W-1:0] : up_data.rem;
    data_nxt.quo = {up_data.quo[QBITS-2:0], take};
    data_nxt.dsh = {1'b0, up_data.dsh[DSH_W-1:1]};
  end

  assign up_rdy = !vld_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      data_r <= data_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_data = data_r;
endmodule

// ----- sv/mp3_frame_header_parser.sv -----
// MPEG audio Layer III frame header parser. One 32-bit header goes in per
// transfer and one result comes out per header, in order. While out_ready
// stays high, the block accepts a header in every cycle and sustains one
// transfer per cycle on both sides. The pipeline is one decode stage (sync
// and field checks, rate and bitrate tables, the bitrate * 144000 multiply),
// a chain of 11 identical divider cells that each settle one bit of the frame
// size quotient, and an output register that adds the padding byte. Every
// stage has its own valid bit, so bubbles close up and a waiting result only
// stops headers entering once all 13 stages hold an item. Rejected headers
// yield all-zero fields.
// Depends on mfhp_pkg, mfhp_decode, mfhp_div_cell and the assertion header.
`include "mp3_frame_header_parser_assert.svh"

module mp3_frame_header_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [31:0]                  in_header_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_valid_res,
  output logic [mfhp_pkg::SIZE_W-1:0]  out_frame_size,
  output logic [mfhp_pkg::CH_W-1:0]    out_channels,
  output logic [mfhp_pkg::RATE_W-1:0]  out_sample_rate,
  output logic [mfhp_pkg::KBPS_W-1:0]  out_bitrate_kbps
);
  import mfhp_pkg::*;

  // link k joins stage k to stage k+1; link 0 leaves the decode stage
  logic      lnk_vld [QBITS+1];
  logic      lnk_rdy [QBITS+1];
  div_data_t lnk_data[QBITS+1];

  logic              out_vld_r;
  logic              res_r;
  logic [SIZE_W-1:0] size_r;
  logic [CH_W-1:0]   chans_r;
  logic [RATE_W-1:0] rate_r;
  logic [KBPS_W-1:0] kbps_r;
  logic              out_take;
  div_data_t         fin;
  logic              fields_zero;
  logic              fields_legal;
  logic              out_stall;

  mfhp_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (in_valid),
    .up_rdy  (in_ready),
    .hdr     (in_header_word),
    .dn_vld  (lnk_vld[0]),
    .dn_rdy  (lnk_rdy[0]),
    .dn_data (lnk_data[0])
  );

  // Divider chain: quotient MSB first, divisor pre-shifted by QBITS-1
  for (genvar g = 0; g < QBITS; g++) begin : g_cell
    mfhp_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_vld  (lnk_vld[g]),
      .up_rdy  (lnk_rdy[g]),
      .up_data (lnk_data[g]),
      .dn_vld  (lnk_vld[g+1]),
      .dn_rdy  (lnk_rdy[g+1]),
      .dn_data (lnk_data[g+1])
    );
  end

  // Output register: free when empty or when its result is being taken
  assign out_take         = !out_vld_r || out_ready;
  assign lnk_rdy[QBITS]   = out_take;
  assign fin              = lnk_data[QBITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_take) begin
      out_vld_r <= lnk_vld[QBITS];
    end
  end

  // Invalid headers carry a meaningless quotient; mask the frame size with ok (the other fields arrive zeroed)
  always_ff @(posedge clk) begin
    if (out_take && lnk_vld[QBITS]) begin
      res_r   <= fin.ok;
      size_r  <= fin.ok ? (fin.quo + SIZE_W'(fin.pad)) : '0;
      chans_r <= fin.chans;
      rate_r  <= fin.rate;
      kbps_r  <= fin.kbps;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_valid_res    = res_r;
  assign out_frame_size   = size_r;
  assign out_channels     = chans_r;
  assign out_sample_rate  = rate_r;
  assign out_bitrate_kbps = kbps_r;

  assign fields_zero  = (out_frame_size == '0) && (out_channels == '0) &&
                        (out_sample_rate == '0) && (out_bitrate_kbps == '0);
  assign fields_legal = (out_frame_size != '0) && (out_channels != '0) &&
                        (out_sample_rate >= 16'd8000) && (out_bitrate_kbps != '0) &&
                        (out_bitrate_kbps <= 9'd320);
  assign out_stall    = out_valid && !out_ready;

  // Rejected header: every field zero
  `MFHP_ASSERT_NOW(a_reject_zero, out_valid && !out_valid_res, fields_zero, "reject not zeroed")
  // Accepted header: fields within their legal ranges
  `MFHP_ASSERT_NOW(a_accept_range, out_valid && out_valid_res, fields_legal, "accept out of range")
  // Input stall only when the decode stage holds an item it cannot pass on
  `MFHP_ASSERT_NOW(a_stall_cause, !in_ready, lnk_vld[0] && !lnk_rdy[0], "input stalled with room")
  // A stalled result must not be overwritten by the chain
  `MFHP_ASSERT_NXT(a_hold_result, out_stall, out_valid && $stable(size_r), "stalled result changed")
endmodule
